// File: src/nvds_pkg.sv
// nvds_pkg: shared types and constants of the nearest valid depth search block
// beat layouts, configuration register map and reset values; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nvds_pkg;

  // field widths fixed by the block's interface
  localparam int unsigned ColW   = 10;
  localparam int unsigned RowW   = 9;
  localparam int unsigned FieldW = 16;
  localparam int unsigned StepW  = 6;
  localparam int unsigned ColsW  = 11;
  localparam int unsigned RowsW  = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SEARCH_STEP = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_ROWS  = 2'd2;

  // configuration reset values
  localparam logic [StepW-1:0] SEARCH_STEP_RST = 6'd1;
  localparam logic [ColsW-1:0] IMAGE_COLS_RST  = 11'd640;
  localparam logic [RowsW-1:0] IMAGE_ROWS_RST  = 10'd480;

  // input beat
  typedef struct packed {
    logic                     action;
    logic [ColW-1:0]          col;
    logic [RowW-1:0]          row;
    logic signed [FieldW-1:0] point_x;
    logic signed [FieldW-1:0] point_y;
    logic signed [FieldW-1:0] point_z;
  } nvds_in_t;

  // result beat
  typedef struct packed {
    logic signed [FieldW-1:0] depth_x;
    logic signed [FieldW-1:0] depth_y;
    logic signed [FieldW-1:0] depth_z;
    logic                     found;
  } nvds_out_t;

  // search geometry handed to the ring sequencer
  typedef struct packed {
    logic [StepW-1:0] step;
    logic [ColsW-1:0] cols;
    logic [RowsW-1:0] rows;
  } nvds_geom_t;

  // ring sequencer status for the current probe
  typedef struct packed {
    logic more;
    logic hit;
  } nvds_probe_t;

endpackage

`default_nettype wire

// File: src/nvds_ram.sv
// nvds_ram: generic single-port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nvds_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 524288
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write or registered read, one access a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/nvds_ring_seq.sv
// nvds_ring_seq: ring walker that yields one probe position and store address a cycle while advanced
// depends on nvds_pkg
`timescale 1ns / 1ps
`default_nettype none

module nvds_ring_seq import nvds_pkg::*; #(
  parameter int unsigned MAX_COLS     = 1024,
  parameter int unsigned MAX_ROWS     = 512,
  parameter int unsigned RADIUS_LIMIT = 50,
  parameter int unsigned AW           = 19
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             init_i,
  input  wire logic             adv_i,
  input  wire nvds_geom_t       geom_i,
  input  wire logic [RowW-1:0]  cen_row_i,
  input  wire logic [ColW-1:0]  cen_col_i,
  output nvds_probe_t           probe_o,
  output logic      [AW-1:0]    addr_o
);

  localparam int unsigned RadW = (RADIUS_LIMIT > 2) ? $clog2(RADIUS_LIMIT) : 1;
  localparam int unsigned NW   = ((RadW > StepW) ? RadW : StepW) + 1;
  localparam int unsigned KW   = NW + 1;
  localparam int unsigned PW   = ((KW > 11) ? KW : 11) + 1;
  localparam logic signed [KW-1:0] KOne = KW'(1);
  localparam logic [NW-1:0] Limit = NW'(RADIUS_LIMIT);

  typedef enum logic [1:0] {
    PH_TOP,
    PH_BOT,
    PH_RIGHT,
    PH_LEFT
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [RadW-1:0]        rad_q, rad_d;
  logic signed [KW-1:0]   k_q, k_d;
  logic                   more_q, more_d;

  logic signed [KW-1:0]   step_k, rad_k, neg_rad, k_dec, k_wall;
  logic [NW-1:0]          rad_next, step_n;
  logic signed [KW-1:0]   dr, dc;
  logic signed [PW-1:0]   pr, pc;
  logic                   hit;

  assign step_k  = $signed({{(KW-StepW){1'b0}}, geom_i.step});
  assign step_n  = NW'(geom_i.step);
  assign rad_k   = $signed({{(KW-RadW){1'b0}}, rad_q});
  assign neg_rad = -rad_k;
  assign k_dec   = k_q - step_k;
  assign k_wall  = rad_k - KOne;
  assign rad_next = NW'(rad_q) + step_n;

  // walk order: top and bottom rows right to left, then right and left walls upward
  always_comb begin
    phase_d = phase_q;
    rad_d   = rad_q;
    k_d     = k_q;
    more_d  = more_q;
    if (init_i) begin
      phase_d = PH_TOP;
      rad_d   = RadW'(geom_i.step);
      k_d     = step_k;
      more_d  = (step_n < Limit);
    end else if (adv_i && more_q) begin
      unique case (phase_q)
        PH_TOP: begin
          phase_d = PH_BOT;
        end
        PH_BOT: begin
          if (k_dec > neg_rad) begin
            phase_d = PH_TOP;
            k_d     = k_dec;
          end else if (k_wall > neg_rad + KOne) begin
            phase_d = PH_RIGHT;
            k_d     = k_wall;
          end else begin
            phase_d = PH_TOP;
            rad_d   = RadW'(rad_next);
            k_d     = KW'(rad_next);
            more_d  = (rad_next < Limit);
          end
        end
        PH_RIGHT: begin
          phase_d = PH_LEFT;
        end
        PH_LEFT: begin
          if (k_dec > neg_rad + KOne) begin
            phase_d = PH_RIGHT;
            k_d     = k_dec;
          end else begin
            phase_d = PH_TOP;
            rad_d   = RadW'(rad_next);
            k_d     = KW'(rad_next);
            more_d  = (rad_next < Limit);
          end
        end
        default: begin
          phase_d = PH_TOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOP;
      rad_q   <= '0;
      k_q     <= '0;
      more_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rad_q   <= rad_d;
      k_q     <= k_d;
      more_q  <= more_d;
    end
  end

  // offsets of the current probe from the centre
  always_comb begin
    unique case (phase_q)
      PH_TOP: begin
        dr = neg_rad;
        dc = k_q;
      end
      PH_BOT: begin
        dr = rad_k;
        dc = k_q;
      end
      PH_RIGHT: begin
        dr = k_q;
        dc = rad_k;
      end
      default: begin
        dr = k_q;
        dc = neg_rad;
      end
    endcase
  end

  // probe position, bounds check and store address
  assign pr  = $signed({{(PW-RowW){1'b0}}, cen_row_i}) + PW'(dr);
  assign pc  = $signed({{(PW-ColW){1'b0}}, cen_col_i}) + PW'(dc);
  assign hit = !pr[PW-1] && !pc[PW-1] &&
               (pr < $signed({{(PW-RowsW){1'b0}}, geom_i.rows})) &&
               (pc < $signed({{(PW-ColsW){1'b0}}, geom_i.cols}));

  assign addr_o       = AW'(int'(pr[RowsW-1:0]) * MAX_COLS + int'(pc[ColsW-1:0]));
  assign probe_o.more = more_q;
  assign probe_o.hit  = hit;

endmodule

`default_nettype wire

// File: src/nearest_valid_depth_search.sv
// nearest_valid_depth_search: top level with point store, control sequencer and config
// depends on nvds_pkg, nvds_ram and nvds_ring_seq
`timescale 1ns / 1ps
`default_nettype none

// A write beat (action 0) stores one point and leaves the block ready at once. A query beat
// (action 1) reads the centre pixel; when its depth is nonzero the result is registered
// from the centre state without a ring search. Otherwise the ring walker visits one ring
// position per cycle, inside or outside the image, and the point store's single read port
// returns one entry per cycle for positions inside the image. busy_o stays high for the
// whole query. The result is shown for exactly one cycle on result_valid_o and cannot be
// held off, so a receiver must take it then. The store needs no clearing pass after reset:
// every pixel is expected to be written before it is queried.
module nearest_valid_depth_search import nvds_pkg::*; #(
  parameter int unsigned MAX_COLS     = 1024,
  parameter int unsigned MAX_ROWS     = 512,
  parameter int unsigned RADIUS_LIMIT = 50,
  parameter int unsigned COORD_BITS   = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire nvds_in_t            in_i,
  output logic                     result_valid_o,
  output nvds_out_t                result_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned Depth = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned WW    = 3 * CB;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CENTRE,
    S_RING
  } state_e;

  state_e            state_q;
  logic [StepW-1:0]  search_step_q;
  logic [ColsW-1:0]  image_cols_q;
  logic [RowsW-1:0]  image_rows_q;
  logic              rd_pend_q;
  logic              cen_hit_q;
  logic              res_valid_q;
  nvds_out_t         res_q;

  logic [RowW-1:0]   cen_row_q;
  logic [ColW-1:0]   cen_col_q;
  logic [WW-1:0]     p_q;

  nvds_geom_t        geom;
  nvds_probe_t       probe;
  logic [AW-1:0]     probe_addr;
  logic [AW-1:0]     pix_addr;
  logic [AW-1:0]     ram_addr;
  logic [WW-1:0]     ram_wdata;
  logic [WW-1:0]     ram_rdata;
  logic              ram_we, ram_re;
  logic              accept, wr_ok, cen_in_img;
  logic [WW-1:0]     p_cen, fin_word, res_word;
  logic              cen_nz, rd_nz, finish;
  logic              seq_init, seq_adv;

  // effective geometry: zero step acts as one, image size saturates at the store size
  always_comb begin
    geom.step = (search_step_q == '0) ? StepW'(1) : search_step_q;
    geom.cols = (int'(image_cols_q) > MAX_COLS) ? ColsW'(MAX_COLS) : image_cols_q;
    geom.rows = (int'(image_rows_q) > MAX_ROWS) ? RowsW'(MAX_ROWS) : image_rows_q;
  end

  // start beat decode
  assign accept     = start_i && (state_q == S_IDLE);
  assign wr_ok      = (int'(in_i.col) < MAX_COLS) && (int'(in_i.row) < MAX_ROWS);
  assign cen_in_img = ({1'b0, in_i.col} < geom.cols) && ({1'b0, in_i.row} < geom.rows);
  assign pix_addr   = AW'(int'(in_i.row) * MAX_COLS + int'(in_i.col));
  assign ram_wdata  = {CB'($unsigned(in_i.point_z)), CB'($unsigned(in_i.point_y)),
                       CB'($unsigned(in_i.point_x))};

  // read data checks
  assign p_cen    = cen_hit_q ? ram_rdata : '0;
  assign cen_nz   = (p_cen[WW-1:2*CB] != '0);
  assign rd_nz    = rd_pend_q && (ram_rdata[WW-1:2*CB] != '0);
  assign fin_word = rd_pend_q ? ram_rdata : p_q;
  assign finish   = (state_q == S_RING) && (rd_nz || !probe.more);
  assign res_word = (state_q == S_CENTRE) ? p_cen : fin_word;

  // ring walker control
  assign seq_init = (state_q == S_CENTRE) && !cen_nz;
  assign seq_adv  = (state_q == S_RING) && !finish;

  // store port: write or centre read on the start beat, ring reads while searching
  assign ram_we   = accept && (in_i.action == ACT_WRITE) && wr_ok;
  assign ram_re   = (accept && (in_i.action == ACT_QUERY) && cen_in_img) ||
                    (seq_adv && probe.hit);
  assign ram_addr = (state_q == S_RING) ? probe_addr : pix_addr;

  nvds_ram #(
    .Width (WW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  nvds_ring_seq #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .RADIUS_LIMIT (RADIUS_LIMIT),
    .AW           (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .init_i    (seq_init),
    .adv_i     (seq_adv),
    .geom_i    (geom),
    .cen_row_i (cen_row_q),
    .cen_col_i (cen_col_q),
    .probe_o   (probe),
    .addr_o    (probe_addr)
  );

  // control state, configuration and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      search_step_q <= SEARCH_STEP_RST;
      image_cols_q  <= IMAGE_COLS_RST;
      image_rows_q  <= IMAGE_ROWS_RST;
      rd_pend_q     <= 1'b0;
      cen_hit_q     <= 1'b0;
      res_valid_q   <= 1'b0;
      res_q         <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SEARCH_STEP: search_step_q <= cfg_wdata_i[StepW-1:0];
          REG_IMAGE_COLS:  image_cols_q  <= cfg_wdata_i[ColsW-1:0];
          REG_IMAGE_ROWS:  image_rows_q  <= cfg_wdata_i[RowsW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (in_i.action == ACT_QUERY)) begin
            cen_hit_q <= cen_in_img;
            state_q   <= S_CENTRE;
          end
        end
        S_CENTRE: begin
          rd_pend_q <= 1'b0;
          if (cen_nz) begin
            res_valid_q <= 1'b1;
            res_q.depth_x <= FieldW'(res_word[CB-1:0]);
            res_q.depth_y <= FieldW'(res_word[2*CB-1:CB]);
            res_q.depth_z <= FieldW'(res_word[WW-1:2*CB]);
            res_q.found   <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_RING;
          end
        end
        S_RING: begin
          if (finish) begin
            res_valid_q <= 1'b1;
            res_q.depth_x <= FieldW'(res_word[CB-1:0]);
            res_q.depth_y <= FieldW'(res_word[2*CB-1:CB]);
            res_q.depth_z <= FieldW'(res_word[WW-1:2*CB]);
            res_q.found   <= (res_word[WW-1:2*CB] != '0);
            rd_pend_q   <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            rd_pend_q <= probe.hit;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // query centre and last point read
  always_ff @(posedge clk_i) begin
    if (accept && (in_i.action == ACT_QUERY)) begin
      cen_row_q <= in_i.row;
      cen_col_q <= in_i.col;
    end
    if (state_q == S_CENTRE) begin
      p_q <= p_cen;
    end else if ((state_q == S_RING) && rd_pend_q) begin
      p_q <= ram_rdata;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// File: src/nvds_checker.sv
// nvds_checker: port-level assertions on the nearest valid depth search block
// depends on nvds_pkg; bound to nearest_valid_depth_search below
`timescale 1ns / 1ps
`default_nettype none

module nvds_checker import nvds_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire nvds_in_t            in_i,
  input wire logic                result_valid_o,
  input wire nvds_out_t           result_o,
  input wire logic                cfg_we_i,
  input wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [CfgDataW-1:0] cfg_wdata_i
);

  // result beat lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // an accepted query makes the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.action == ACT_QUERY)) |=> busy_o)
    else $error("query accepted but block not busy");

  // an accepted write completes at once and gives no result
  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.action == ACT_WRITE)) |=> (!busy_o && !result_valid_o))
    else $error("write beat caused busy or a result");

  // a result only ends a busy query
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result beat without a query in progress");

  // found flag follows the returned depth
  a_found_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.found == (result_o.depth_z != '0)))
    else $error("found flag disagrees with returned depth");

  // config port is used only by the check below, on zero writes to the search step register
  logic cfg_seen;
  assign cfg_seen = cfg_we_i && (cfg_idx_i == REG_SEARCH_STEP) && (cfg_wdata_i == '0);

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_seen |-> !result_valid_o || !busy_o)
    else $error("configuration write while a result and a query overlap");

endmodule

bind nearest_valid_depth_search nvds_checker u_nvds_checker (.*);

`default_nettype wire
